>>> design/assert_macros.svh
// Assertion macros used by the checker module lgs_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LGS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("Assertion failed: same-cycle implication.");

// Next-cycle implication, disabled while reset is asserted.
`define LGS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("Assertion failed: next-cycle implication.");

`endif

>>> design/lgs_pkg.sv
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared types and constants of the life grid stepper: request codes, field
// widths, default grid size, rule thresholds and the control state type.
// ----------------------------------------------------------------------------
package lgs_pkg;

  localparam int REQ_W   = 2;
  localparam int COORD_W = 7;

  localparam int GRID_W_DEF = 128;
  localparam int GRID_H_DEF = 128;

  localparam logic [REQ_W-1:0] REQ_BIRTH = 2'd0;
  localparam logic [REQ_W-1:0] REQ_STEP  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  localparam logic [3:0] LIVE_KEEP  = 4'd2;
  localparam logic [3:0] LIVE_BIRTH = 4'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_STEP_LOAD,
    ST_STEP_RUN
  } state_t;

endpackage

>>> design/life_grid_stepper.sv
// Birth, read and unused requests: accept moves to ST_ACCESS, and the result strobe is registered from there.
// Step requests: the result strobe is registered after ST_STEP_LOAD and the ST_STEP_RUN sweep; the sweep
// computes one full row per cycle through the single read port of the row memory.
// A new request is taken only in ST_IDLE, once the previous one is done; no output stall.
// busy is high while the block is out of ST_IDLE: low in the accept cycle, it falls as the result strobe rises.
// After reset, a clearing pass writes every row dead with busy high.
// ----------------------------------------------------------------------------
// life_grid_stepper
// Conway B3/S23 grid with non-wrapping edges, held in a row-wide memory and
// advanced in place with two row line buffers.
// ----------------------------------------------------------------------------
module life_grid_stepper
  import lgs_pkg::*;
#(
  parameter int GRID_W = GRID_W_DEF,
  parameter int GRID_H = GRID_H_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [REQ_W-1:0]   in_req_type,
  input  logic [COORD_W-1:0] in_col,
  input  logic [COORD_W-1:0] in_row,
  output logic               out_valid,
  output logic               out_cell_alive
);

  localparam int AW = $clog2(GRID_H);
  localparam int CW = $clog2(GRID_W);

  logic [GRID_W-1:0] mem [GRID_H];
  logic [GRID_W-1:0] rd_data_r;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [GRID_W-1:0] wr_data;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     y_r, y_nxt;
  logic [GRID_W-1:0] above_r, above_nxt;
  logic [GRID_W-1:0] cur_r, cur_nxt;
  logic [REQ_W-1:0]  req_type_r, req_type_nxt;
  logic [COORD_W-1:0] col_r, col_nxt;
  logic [COORD_W-1:0] row_r, row_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_cell_alive_r, out_cell_alive_nxt;

  logic              last_row;
  logic              on_grid;
  logic [CW-1:0]     col_idx;
  logic [AW:0]       y_plus2;
  logic [GRID_W-1:0] below;
  logic [GRID_W+1:0] pad_a, pad_c, pad_b;
  logic [GRID_W-1:0] next_row;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign last_row = (y_r == AW'(GRID_H - 1));
  assign on_grid  = (32'(col_r) < GRID_W) && (32'(row_r) < GRID_H);
  assign col_idx  = CW'(col_r);
  assign y_plus2  = {1'b0, y_r} + (AW + 1)'(2);
  assign below    = last_row ? '0 : rd_data_r;

  always_comb begin
    logic [3:0] n;
    pad_a = {1'b0, above_r, 1'b0};
    pad_c = {1'b0, cur_r, 1'b0};
    pad_b = {1'b0, below, 1'b0};
    for (int x = 0; x < GRID_W; x++) begin
      n = 4'(pad_a[x]) + 4'(pad_a[x+1]) + 4'(pad_a[x+2]) + 4'(pad_c[x]) +
          4'(pad_c[x+2]) + 4'(pad_b[x]) + 4'(pad_b[x+1]) + 4'(pad_b[x+2]);
      next_row[x] = (n == LIVE_BIRTH) || (pad_c[x+1] && (n == LIVE_KEEP));
    end
  end

  always_comb begin
    state_nxt          = state_r;
    y_nxt              = y_r;
    above_nxt          = above_r;
    cur_nxt            = cur_r;
    req_type_nxt       = req_type_r;
    col_nxt            = col_r;
    row_nxt            = row_r;
    out_valid_nxt      = 1'b0;
    out_cell_alive_nxt = 1'b0;
    rd_en              = 1'b0;
    rd_addr            = '0;
    wr_en              = 1'b0;
    wr_addr            = y_r;
    wr_data            = '0;
    case (state_r)
      ST_CLEAR: begin
        wr_en = 1'b1;
        y_nxt = y_r + AW'(1);
        if (last_row) begin
          y_nxt     = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          req_type_nxt = in_req_type;
          col_nxt      = in_col;
          row_nxt      = in_row;
          rd_en        = 1'b1;
          if (in_req_type == REQ_STEP) begin
            rd_addr   = '0;
            y_nxt     = '0;
            above_nxt = '0;
            state_nxt = ST_STEP_LOAD;
          end else begin
            rd_addr   = AW'(in_row);
            state_nxt = ST_ACCESS;
          end
        end
      end
      ST_ACCESS: begin
        wr_addr       = AW'(row_r);
        wr_data       = rd_data_r | (GRID_W'(1) << col_idx);
        wr_en         = on_grid && (req_type_r == REQ_BIRTH);
        out_valid_nxt = 1'b1;
        out_cell_alive_nxt = on_grid && (req_type_r == REQ_READ) && rd_data_r[col_idx];
        state_nxt     = ST_IDLE;
      end
      ST_STEP_LOAD: begin
        cur_nxt   = rd_data_r;
        rd_en     = 1'b1;
        rd_addr   = AW'(1);
        state_nxt = ST_STEP_RUN;
      end
      ST_STEP_RUN: begin
        wr_en     = 1'b1;
        wr_data   = next_row;
        above_nxt = cur_r;
        cur_nxt   = below;
        rd_en     = (y_plus2 < (AW + 1)'(GRID_H));
        rd_addr   = AW'(y_plus2);
        y_nxt     = y_r + AW'(1);
        if (last_row) begin
          y_nxt         = '0;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_CLEAR;
      y_r              <= '0;
      out_valid_r      <= 1'b0;
      out_cell_alive_r <= 1'b0;
    end else begin
      state_r          <= state_nxt;
      y_r              <= y_nxt;
      out_valid_r      <= out_valid_nxt;
      out_cell_alive_r <= out_cell_alive_nxt;
    end
  end

  always_ff @(posedge clk) begin
    above_r    <= above_nxt;
    cur_r      <= cur_nxt;
    req_type_r <= req_type_nxt;
    col_r      <= col_nxt;
    row_r      <= row_nxt;
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_cell_alive = out_cell_alive_r;

endmodule

>>> design/lgs_checker.sv
// ----------------------------------------------------------------------------
// lgs_checker
// Port-level checks of the life grid stepper's command handshake and result
// timing, bound to every instance of the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lgs_checker
  import lgs_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic [REQ_W-1:0]   in_req_type,
  input logic               out_valid
);

  logic short_accept;

  assign short_accept = start && !busy && (in_req_type != REQ_STEP);

  `LGS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, start && !busy, busy)
  `LGS_ASSERT_IMPL(a_idle_with_result, clk, rst_n, out_valid, !busy)
  `LGS_ASSERT_NEXT(a_no_back_to_back_result, clk, rst_n, out_valid, !out_valid)
  `LGS_ASSERT_IMPL(a_short_request_latency, clk, rst_n, short_accept, ##2 out_valid)

endmodule

bind life_grid_stepper lgs_checker u_lgs_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .in_req_type (in_req_type),
  .out_valid   (out_valid)
);

>>> dv/life_grid_stepper_chk.sv
// ----------------------------------------------------------------------------
// life_grid_stepper_chk
// Watches the request and result channels of the life grid stepper. It keeps
// its own copy of the grid and predicts one result word per accepted request.
// Each result word is then compared with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module life_grid_stepper_chk
  import lgs_pkg::*;
#(
  parameter int GRID_W = GRID_W_DEF,
  parameter int GRID_H = GRID_H_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [REQ_W-1:0]   in_req_type,
  input  logic [COORD_W-1:0] in_col,
  input  logic [COORD_W-1:0] in_row,
  input  logic               out_valid,
  input  logic               out_cell_alive,
  output int                 mismatch_count,
  output int                 words_in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  bit [GRID_W-1:0] cells [GRID_H];
  bit              expected_alive_q [$];

  function automatic void advance_generation();
    bit [GRID_W-1:0] prev [GRID_H];
    int              live;
    prev = cells;
    for (int y = 0; y < GRID_H; y++) begin
      for (int x = 0; x < GRID_W; x++) begin
        live = 0;
        for (int dy = -1; dy <= 1; dy++) begin
          for (int dx = -1; dx <= 1; dx++) begin
            if ((dy != 0 || dx != 0) && y + dy >= 0 && y + dy < GRID_H &&
                x + dx >= 0 && x + dx < GRID_W) begin
              live += prev[y+dy][x+dx];
            end
          end
        end
        if (prev[y][x]) begin
          cells[y][x] = (live == LIVE_KEEP || live == LIVE_BIRTH);
        end else begin
          cells[y][x] = (live == LIVE_BIRTH);
        end
      end
    end
  endfunction

  function automatic bit serve_request(logic [REQ_W-1:0] req, int col, int row);
    bit on_grid;
    on_grid = (col < GRID_W) && (row < GRID_H);
    case (req)
      REQ_BIRTH: begin
        if (on_grid) cells[row][col] = 1'b1;
      end
      REQ_STEP: begin
        advance_generation();
      end
      REQ_READ: begin
        if (on_grid) return cells[row][col];
      end
      default: begin
      end
    endcase
    return 1'b0;
  endfunction

  always @(posedge clk) begin : monitor
    bit want;
    bit pred;
    if (!rst_n) begin
      foreach (cells[y]) cells[y] = '0;
      expected_alive_q.delete();
    end else begin
      if (out_valid === 1'b1) begin
        if (expected_alive_q.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual cell_alive %0b",
                   $time, out_cell_alive);
          mismatch_count++;
        end else begin
          want = expected_alive_q.pop_front();
          if (out_cell_alive !== want) begin
            $display("%0t: cell_alive mismatch, expected %0b, actual %0b",
                     $time, want, out_cell_alive);
            mismatch_count++;
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        pred = serve_request(in_req_type, int'(in_col), int'(in_row));
        expected_alive_q = {expected_alive_q, pred};
      end
    end
    words_in_flight = expected_alive_q.size();
  end

endmodule

>>> dv/life_grid_stepper_tb.sv
// ----------------------------------------------------------------------------
// life_grid_stepper_tb
// Drives birth, step, read and unused requests into the life grid stepper,
// first a directed set around the grid edges and corners, then random
// requests clustered in small windows so that patterns form and evolve.
// A checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module life_grid_stepper_tb;
  import lgs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int               GRID_W     = GRID_W_DEF;
  localparam int               GRID_H     = GRID_H_DEF;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int               CYCLE_CAP  = 200000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [REQ_W-1:0]   in_req_type;
  logic [COORD_W-1:0] in_col;
  logic [COORD_W-1:0] in_row;
  logic               out_valid;
  logic               out_cell_alive;
  int                 mismatch_count;
  int                 words_in_flight;
  int                 cycle_count;

  life_grid_stepper #(
    .GRID_W(GRID_W),
    .GRID_H(GRID_H)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_col        (in_col),
    .in_row        (in_row),
    .out_valid     (out_valid),
    .out_cell_alive(out_cell_alive)
  );

  life_grid_stepper_chk #(
    .GRID_W(GRID_W),
    .GRID_H(GRID_H)
  ) i_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_col         (in_col),
    .in_row         (in_row),
    .out_valid      (out_valid),
    .out_cell_alive (out_cell_alive),
    .mismatch_count (mismatch_count),
    .words_in_flight(words_in_flight)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_CAP) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Called at a falling edge; returns at a falling edge with start still high
  // when no gap follows, so back-to-back words keep start asserted.
  task automatic send_word(logic [REQ_W-1:0] req, int col, int row);
    int gap;
    gap = pick_gap();
    in_req_type <= req;
    in_col      <= COORD_W'(col);
    in_row      <= COORD_W'(row);
    start       <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) begin
        in_req_type <= REQ_W'($urandom);
        in_col      <= COORD_W'($urandom);
        in_row      <= COORD_W'($urandom);
        @(negedge clk);
      end
    end
  endtask

  initial begin
    int win_x;
    int win_y;
    int r;
    int cx;
    int cy;
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_req_type <= REQ_BIRTH;
    in_col      <= '0;
    in_row      <= '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    send_word(REQ_READ, 0, 0);
    send_word(REQ_BIRTH, 0, 0);
    send_word(REQ_BIRTH, GRID_W - 1, 0);
    send_word(REQ_BIRTH, 0, GRID_H - 1);
    send_word(REQ_BIRTH, GRID_W - 1, GRID_H - 1);
    send_word(REQ_READ, GRID_W - 1, GRID_H - 1);
    // A vertical bar on the right edge must not spill over to column 0.
    send_word(REQ_BIRTH, GRID_W - 1, 10);
    send_word(REQ_BIRTH, GRID_W - 1, 11);
    send_word(REQ_BIRTH, GRID_W - 1, 12);
    // A horizontal bar on the top row must not spill over to the bottom row.
    send_word(REQ_BIRTH, 40, 0);
    send_word(REQ_BIRTH, 41, 0);
    send_word(REQ_BIRTH, 42, 0);
    send_word(REQ_UNUSED, GRID_W - 1, GRID_H - 1);
    send_word(REQ_STEP, GRID_W - 1, GRID_H - 1);
    send_word(REQ_READ, 0, 11);
    send_word(REQ_READ, GRID_W - 2, 11);
    send_word(REQ_READ, 41, 1);
    send_word(REQ_READ, 41, GRID_H - 1);
    send_word(REQ_READ, 0, 0);
    send_word(REQ_BIRTH, GRID_W - 2, 11);
    send_word(REQ_BIRTH, GRID_W - 2, GRID_H - 2);
    send_word(REQ_BIRTH, GRID_W - 1, GRID_H - 2);
    send_word(REQ_BIRTH, GRID_W - 2, GRID_H - 1);
    send_word(REQ_STEP, 0, 0);
    send_word(REQ_READ, GRID_W - 1, GRID_H - 1);

    win_x = 0;
    win_y = 0;
    for (int i = 0; i < 75; i++) begin
      if (i % 20 == 0) begin
        case ($urandom_range(0, 3))
          0:       win_x = 0;
          1:       win_x = GRID_W - 8;
          default: win_x = $urandom_range(0, GRID_W - 8);
        endcase
        case ($urandom_range(0, 3))
          0:       win_y = 0;
          1:       win_y = GRID_H - 8;
          default: win_y = $urandom_range(0, GRID_H - 8);
        endcase
      end
      r  = $urandom_range(0, 99);
      cx = win_x + $urandom_range(0, 7);
      cy = win_y + $urandom_range(0, 7);
      if (r < 42) begin
        send_word(REQ_BIRTH, cx, cy);
      end else if (r < 78) begin
        send_word(REQ_READ, cx, cy);
      end else if (r < 88) begin
        send_word(REQ_STEP, $urandom_range(0, GRID_W - 1), $urandom_range(0, GRID_H - 1));
      end else if (r < 93) begin
        send_word(REQ_UNUSED, $urandom_range(0, GRID_W - 1), $urandom_range(0, GRID_H - 1));
      end else if (r < 97) begin
        send_word(REQ_READ, $urandom_range(0, GRID_W - 1), $urandom_range(0, GRID_H - 1));
      end else begin
        send_word(REQ_BIRTH, $urandom_range(0, GRID_W - 1), $urandom_range(0, GRID_H - 1));
      end
    end
    start <= 1'b0;

    while (words_in_flight != 0) @(negedge clk);
    repeat (GRID_H + 4) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/lgs_pkg.sv
design/life_grid_stepper.sv
design/lgs_checker.sv
dv/life_grid_stepper_chk.sv
dv/life_grid_stepper_tb.sv
